@@ sv/rc2d_pkg.sv @@
// shared constants and status codes for the ray crossing block
package rc2d_pkg;

  localparam int unsigned POS_BITS_DEF  = 48;
  localparam int unsigned VEL_BITS_DEF  = 12;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PT_BITS       = 64;

  localparam logic [1:0] ST_CROSS         = 2'd0;
  localparam logic [1:0] ST_PARALLEL      = 2'd1;
  localparam logic [1:0] ST_BEHIND_SECOND = 2'd2;
  localparam logic [1:0] ST_BEHIND_FIRST  = 2'd3;

endpackage

@@ sv/rc2d_ifs.sv @@
// valid/ready channel interfaces for ray pairs and crossing results
interface rc2d_ray_if #(
  parameter int unsigned POS_BITS = 48,
  parameter int unsigned VEL_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] first_pos_x;
  logic signed [POS_BITS-1:0] first_pos_y;
  logic signed [VEL_BITS-1:0] first_vel_x;
  logic signed [VEL_BITS-1:0] first_vel_y;
  logic signed [POS_BITS-1:0] second_pos_x;
  logic signed [POS_BITS-1:0] second_pos_y;
  logic signed [VEL_BITS-1:0] second_vel_x;
  logic signed [VEL_BITS-1:0] second_vel_y;

  modport source (
    output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
           second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
           second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    output ready
  );
endinterface

interface rc2d_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [63:0] point_x;
  logic signed [63:0] point_y;

  modport source (output valid, status, point_x, point_y, input ready);
  modport sink (input valid, status, point_x, point_y, output ready);
endinterface

@@ sv/rc2d_front.sv @@
// cross products, status decision and dividend setup, four register stages
module rc2d_front #(
  parameter int unsigned POS_BITS  = 48,
  parameter int unsigned VEL_BITS  = 12,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned DW  = 2 * VEL_BITS + 1,
  localparam int unsigned DVW = POS_BITS + 2 * VEL_BITS + 3 + FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic signed [POS_BITS-1:0] p1x_i,
  input  logic signed [POS_BITS-1:0] p1y_i,
  input  logic signed [VEL_BITS-1:0] v1x_i,
  input  logic signed [VEL_BITS-1:0] v1y_i,
  input  logic signed [POS_BITS-1:0] p2x_i,
  input  logic signed [POS_BITS-1:0] p2y_i,
  input  logic signed [VEL_BITS-1:0] v2x_i,
  input  logic signed [VEL_BITS-1:0] v2y_i,
  output logic                       vld_o,
  output logic [1:0]                 sts_o,
  output logic [1:0]                 neg_o,
  output logic [DW-1:0]              dmag_o,
  output logic [1:0][DVW-1:0]        dvd_o
);
  import rc2d_pkg::*;

  localparam int unsigned DXW = POS_BITS + 1;
  localparam int unsigned RNW = POS_BITS + VEL_BITS + 2;
  localparam int unsigned PL  = POS_BITS / 2;
  localparam int unsigned PH  = POS_BITS - PL;
  localparam int unsigned LOW = PL + 1 + DW;
  localparam int unsigned HIW = PH + DW;
  localparam int unsigned RVW = RNW + VEL_BITS;
  localparam int unsigned NW  = POS_BITS + 2 * VEL_BITS + 3;

  // stage 1
  logic                       s1_vld_q;
  logic signed [DXW-1:0]      s1_dx_q, s1_dy_q;
  logic signed [DW-1:0]       s1_den_q;
  logic signed [VEL_BITS-1:0] s1_v1x_q, s1_v1y_q, s1_v2x_q, s1_v2y_q;
  logic signed [POS_BITS-1:0] s1_p2x_q, s1_p2y_q;
  logic signed [DXW-1:0]      s1_dx_d, s1_dy_d;
  logic signed [DW-1:0]       s1_den_d;

  assign s1_dx_d  = DXW'(p2x_i) - DXW'(p1x_i);
  assign s1_dy_d  = DXW'(p2y_i) - DXW'(p1y_i);
  assign s1_den_d = DW'(v1x_i) * DW'(v2y_i) - DW'(v1y_i) * DW'(v2x_i);

  // stage 2
  logic                       s2_vld_q;
  logic signed [RNW-1:0]      s2_rn_q, s2_tn_q;
  logic signed [DW-1:0]       s2_den_q;
  logic signed [VEL_BITS-1:0] s2_v2x_q, s2_v2y_q;
  logic signed [POS_BITS-1:0] s2_p2x_q, s2_p2y_q;
  logic signed [RNW-1:0]      s2_rn_d, s2_tn_d;

  assign s2_rn_d = RNW'(s1_v1y_q) * RNW'(s1_dx_q) - RNW'(s1_v1x_q) * RNW'(s1_dy_q);
  assign s2_tn_d = RNW'(s1_v2y_q) * RNW'(s1_dx_q) - RNW'(s1_v2x_q) * RNW'(s1_dy_q);

  // stage 3
  logic                  s3_vld_q;
  logic [1:0]            s3_sts_q;
  logic signed [DW-1:0]  s3_den_q;
  logic signed [LOW-1:0] s3_lox_q, s3_loy_q;
  logic signed [HIW-1:0] s3_hix_q, s3_hiy_q;
  logic signed [RVW-1:0] s3_rvx_q, s3_rvy_q;
  logic [1:0]            s3_sts_d;
  logic signed [LOW-1:0] s3_lox_d, s3_loy_d;
  logic signed [HIW-1:0] s3_hix_d, s3_hiy_d;
  logic signed [RVW-1:0] s3_rvx_d, s3_rvy_d;
  logic                  den_neg;

  assign den_neg = s2_den_q[DW-1];

  always_comb begin
    if (s2_den_q == '0) begin
      s3_sts_d = ST_PARALLEL;
    end else if (s2_rn_q != '0 && (s2_rn_q[RNW-1] != den_neg)) begin
      s3_sts_d = ST_BEHIND_SECOND;
    end else if (s2_tn_q != '0 && (s2_tn_q[RNW-1] != den_neg)) begin
      s3_sts_d = ST_BEHIND_FIRST;
    end else begin
      s3_sts_d = ST_CROSS;
    end
  end

  assign s3_lox_d = LOW'($signed({1'b0, s2_p2x_q[PL-1:0]})) * LOW'(s2_den_q);
  assign s3_loy_d = LOW'($signed({1'b0, s2_p2y_q[PL-1:0]})) * LOW'(s2_den_q);
  assign s3_hix_d = HIW'($signed(s2_p2x_q[POS_BITS-1:PL])) * HIW'(s2_den_q);
  assign s3_hiy_d = HIW'($signed(s2_p2y_q[POS_BITS-1:PL])) * HIW'(s2_den_q);
  assign s3_rvx_d = RVW'(s2_rn_q) * RVW'(s2_v2x_q);
  assign s3_rvy_d = RVW'(s2_rn_q) * RVW'(s2_v2y_q);

  // stage 4
  logic signed [NW-1:0] numx, numy;
  logic [NW-1:0]        magx, magy;
  logic [DW-1:0]        dmag_d;

  assign numx = (NW'(s3_hix_q) <<< PL) + NW'(s3_lox_q) + NW'(s3_rvx_q);
  assign numy = (NW'(s3_hiy_q) <<< PL) + NW'(s3_loy_q) + NW'(s3_rvy_q);
  assign magx = numx[NW-1] ? NW'(-numx) : NW'(numx);
  assign magy = numy[NW-1] ? NW'(-numy) : NW'(numy);
  assign dmag_d = s3_den_q[DW-1] ? DW'(-s3_den_q) : DW'(s3_den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      vld_o    <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      vld_o    <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q  <= s1_dx_d;
      s1_dy_q  <= s1_dy_d;
      s1_den_q <= s1_den_d;
      s1_v1x_q <= v1x_i;
      s1_v1y_q <= v1y_i;
      s1_v2x_q <= v2x_i;
      s1_v2y_q <= v2y_i;
      s1_p2x_q <= p2x_i;
      s1_p2y_q <= p2y_i;

      s2_rn_q  <= s2_rn_d;
      s2_tn_q  <= s2_tn_d;
      s2_den_q <= s1_den_q;
      s2_v2x_q <= s1_v2x_q;
      s2_v2y_q <= s1_v2y_q;
      s2_p2x_q <= s1_p2x_q;
      s2_p2y_q <= s1_p2y_q;

      s3_sts_q <= s3_sts_d;
      s3_den_q <= s2_den_q;
      s3_lox_q <= s3_lox_d;
      s3_loy_q <= s3_loy_d;
      s3_hix_q <= s3_hix_d;
      s3_hiy_q <= s3_hiy_d;
      s3_rvx_q <= s3_rvx_d;
      s3_rvy_q <= s3_rvy_d;

      sts_o    <= s3_sts_q;
      neg_o    <= {numy[NW-1] ^ s3_den_q[DW-1], numx[NW-1] ^ s3_den_q[DW-1]};
      dmag_o   <= dmag_d;
      dvd_o[0] <= DVW'(magx) << FRAC_BITS;
      dvd_o[1] <= DVW'(magy) << FRAC_BITS;
    end
  end

endmodule

@@ sv/rc2d_cell.sv @@
// one restoring division step for both axes, one quotient bit per cell
module rc2d_cell #(
  parameter int unsigned DW  = 25,
  parameter int unsigned DVW = 91
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [1:0]                          sts_i,
  input  logic [1:0]                          neg_i,
  input  logic [DW-1:0]                       d_i,
  input  logic [1:0][DW-1:0]                  rem_i,
  input  logic [1:0][DVW-1:0]                 dvd_i,
  input  logic [1:0][rc2d_pkg::PT_BITS-1:0]   q_i,
  input  logic [1:0]                          ovf_i,
  output logic                                vld_o,
  output logic [1:0]                          sts_o,
  output logic [1:0]                          neg_o,
  output logic [DW-1:0]                       d_o,
  output logic [1:0][DW-1:0]                  rem_o,
  output logic [1:0][DVW-1:0]                 dvd_o,
  output logic [1:0][rc2d_pkg::PT_BITS-1:0]   q_o,
  output logic [1:0]                          ovf_o
);
  import rc2d_pkg::*;

  logic [1:0][DW:0]        shf;
  logic [1:0]              ge;
  logic [1:0][DW-1:0]      rem_d;
  logic [1:0][PT_BITS-1:0] q_d;
  logic [1:0]              ovf_d;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      shf[k]   = {rem_i[k], dvd_i[k][DVW-1]};
      ge[k]    = shf[k] >= {1'b0, d_i};
      rem_d[k] = ge[k] ? DW'(shf[k] - {1'b0, d_i}) : shf[k][DW-1:0];
      q_d[k]   = {q_i[k][PT_BITS-2:0], ge[k]};
      ovf_d[k] = ovf_i[k] | q_i[k][PT_BITS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sts_o <= sts_i;
      neg_o <= neg_i;
      d_o   <= d_i;
      rem_o <= rem_d;
      dvd_o[0] <= dvd_i[0] << 1;
      dvd_o[1] <= dvd_i[1] << 1;
      q_o   <= q_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

@@ sv/ray_crossing_2d.sv @@
// top level: ray pair crossing test with pipelined fixed point divider chain
//
// channel | dir | payload
// ray_i   | in  | two rays: start point and velocity each
// res_o   | out | status and crossing point, fixed point
//
// one ray pair per cycle while no result waits untaken; DVW is the
// dividend width POS_BITS + 2*VEL_BITS + 3 + FRAC_BITS (91 at defaults),
// one divider cell per quotient bit. reset clears all valid bits only.
// the whole pipe holds while a result waits untaken, bubbles included.
module ray_crossing_2d #(
  parameter int unsigned POS_BITS  = rc2d_pkg::POS_BITS_DEF,
  parameter int unsigned VEL_BITS  = rc2d_pkg::VEL_BITS_DEF,
  parameter int unsigned FRAC_BITS = rc2d_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rc2d_ray_if.sink   ray_i,
  rc2d_res_if.source res_o
);
  import rc2d_pkg::*;

  localparam int unsigned DW  = 2 * VEL_BITS + 1;
  localparam int unsigned DVW = POS_BITS + 2 * VEL_BITS + 3 + FRAC_BITS;

  logic en;
  logic out_vld_q;

  logic [DVW:0]                    c_vld;
  logic [DVW:0][1:0]               c_sts;
  logic [DVW:0][1:0]               c_neg;
  logic [DVW:0][DW-1:0]            c_d;
  logic [DVW:0][1:0][DW-1:0]       c_rem;
  logic [DVW:0][1:0][DVW-1:0]      c_dvd;
  logic [DVW:0][1:0][PT_BITS-1:0]  c_q;
  logic [DVW:0][1:0]               c_ovf;

  assign en          = !out_vld_q || res_o.ready;
  assign ray_i.ready = en;

  rc2d_front #(
    .POS_BITS (POS_BITS),
    .VEL_BITS (VEL_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ray_i.valid),
    .p1x_i  (ray_i.first_pos_x),
    .p1y_i  (ray_i.first_pos_y),
    .v1x_i  (ray_i.first_vel_x),
    .v1y_i  (ray_i.first_vel_y),
    .p2x_i  (ray_i.second_pos_x),
    .p2y_i  (ray_i.second_pos_y),
    .v2x_i  (ray_i.second_vel_x),
    .v2y_i  (ray_i.second_vel_y),
    .vld_o  (c_vld[0]),
    .sts_o  (c_sts[0]),
    .neg_o  (c_neg[0]),
    .dmag_o (c_d[0]),
    .dvd_o  (c_dvd[0])
  );

  assign c_rem[0] = '0;
  assign c_q[0]   = '0;
  assign c_ovf[0] = '0;

  for (genvar i = 0; i < DVW; i++) begin : g_cell
    rc2d_cell #(
      .DW (DW),
      .DVW(DVW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (c_vld[i]),
      .sts_i  (c_sts[i]),
      .neg_i  (c_neg[i]),
      .d_i    (c_d[i]),
      .rem_i  (c_rem[i]),
      .dvd_i  (c_dvd[i]),
      .q_i    (c_q[i]),
      .ovf_i  (c_ovf[i]),
      .vld_o  (c_vld[i+1]),
      .sts_o  (c_sts[i+1]),
      .neg_o  (c_neg[i+1]),
      .d_o    (c_d[i+1]),
      .rem_o  (c_rem[i+1]),
      .dvd_o  (c_dvd[i+1]),
      .q_o    (c_q[i+1]),
      .ovf_o  (c_ovf[i+1])
    );
  end

  logic [1:0][PT_BITS-1:0] pt_d;
  logic [1:0][PT_BITS-1:0] pt_q;
  logic [1:0]              sts_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (c_sts[DVW] != ST_CROSS) begin
        pt_d[k] = '0;
      end else if (c_ovf[DVW][k] || c_q[DVW][k][PT_BITS-1]) begin
        pt_d[k] = c_neg[DVW][k] ? {1'b1, {(PT_BITS-1){1'b0}}}
                                : {1'b0, {(PT_BITS-1){1'b1}}};
      end else begin
        pt_d[k] = c_neg[DVW][k] ? PT_BITS'(-c_q[DVW][k]) : c_q[DVW][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c_vld[DVW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sts_q <= c_sts[DVW];
      pt_q  <= pt_d;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.status  = sts_q;
  assign res_o.point_x = $signed(pt_q[0]);
  assign res_o.point_y = $signed(pt_q[1]);

endmodule

@@ dv/ray_crossing_2d_test.sv @@
// testbench for ray_crossing_2d: directed and random ray pairs against a local predictor
`timescale 1ns / 1ps
module ray_crossing_2d_test;
  import rc2d_pkg::*;

  localparam int unsigned PW = POS_BITS_DEF;
  localparam int unsigned VW = VEL_BITS_DEF;
  localparam int unsigned FW = FRAC_BITS_DEF;
  localparam int unsigned N_RANDOM = 1330;
  localparam int unsigned SETTLE = 5 + PW + 2 * VW + 3 + FW + 20;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic          hold;
    logic signed [PW-1:0] p1x, p1y;
    logic signed [VW-1:0] v1x, v1y;
    logic signed [PW-1:0] p2x, p2y;
    logic signed [VW-1:0] v2x, v2y;
  } ray_pair_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] px, py;
  } crossing_t;

  logic clk_i;
  logic rst_ni;

  rc2d_ray_if #(.POS_BITS(PW), .VEL_BITS(VW)) ray_ch ();
  rc2d_res_if res_ch ();

  ray_crossing_2d #(.POS_BITS(PW), .VEL_BITS(VW), .FRAC_BITS(FW)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ray_i  (ray_ch.sink),
    .res_o  (res_ch.source)
  );

  ray_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  ray_pair_t cur_pair;
  int        gap_left, burst_left;
  int        fails, sent_cnt, got_cnt;
  int        status_cnt[4];
  longint unsigned cyc;
  logic      stimulus_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] fixed_quotient(logic signed [127:0] num,
                                                 logic signed [127:0] den);
    logic        neg;
    logic [127:0] n, d, q;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << FW) / d;
    if (q[127:63] != '0) return neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic crossing_t crossing_of(ray_pair_t a);
    logic signed [127:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic signed [127:0] dx, dy, den, rnum, tnum;
    crossing_t res;
    p1x = a.p1x; p1y = a.p1y; v1x = a.v1x; v1y = a.v1y;
    p2x = a.p2x; p2y = a.p2y; v2x = a.v2x; v2y = a.v2y;
    dx = p2x - p1x;
    dy = p2y - p1y;
    den = v1x * v2y - v1y * v2x;
    res = '0;
    if (den == 0) begin
      res.status = ST_PARALLEL;
      return res;
    end
    rnum = v1y * dx - v1x * dy;
    if (rnum != 0 && rnum[127] != den[127]) begin
      res.status = ST_BEHIND_SECOND;
      return res;
    end
    tnum = v2y * dx - v2x * dy;
    if (tnum != 0 && tnum[127] != den[127]) begin
      res.status = ST_BEHIND_FIRST;
      return res;
    end
    res.status = ST_CROSS;
    res.px = fixed_quotient(p2x * den + rnum * v2x, den);
    res.py = fixed_quotient(p2y * den + rnum * v2y, den);
    return res;
  endfunction

  function automatic logic [PW-1:0] rnd_pos();
    return PW'({$urandom, $urandom});
  endfunction

  function automatic ray_pair_t random_pair();
    ray_pair_t a;
    int mode, t, r;
    logic signed [PW-1:0] cx, cy;
    a = '0;
    mode = $urandom_range(0, 9);
    a.p1x = rnd_pos(); a.p1y = rnd_pos(); a.p2x = rnd_pos(); a.p2y = rnd_pos();
    a.v1x = VW'($urandom); a.v1y = VW'($urandom);
    a.v2x = VW'($urandom); a.v2y = VW'($urandom);
    case (mode)
      0, 1: ;
      2: begin
        a.p1x = $signed(a.p1x) >>> 28; a.p1y = $signed(a.p1y) >>> 28;
        a.p2x = $signed(a.p2x) >>> 28; a.p2y = $signed(a.p2y) >>> 28;
        a.v1x = $signed(a.v1x) >>> $urandom_range(0, 10);
        a.v2y = $signed(a.v2y) >>> $urandom_range(0, 10);
      end
      3: begin
        a.v2x = ($urandom_range(0, 1)) ? a.v1x : -a.v1x;
        a.v2y = (a.v2x == a.v1x) ? a.v1y : -a.v1y;
        if ($urandom_range(0, 3) == 0) begin
          a.v2x = '0; a.v2y = '0;
        end
      end
      default: begin
        a.p1x = $signed(a.p1x) >>> 8; a.p1y = $signed(a.p1y) >>> 8;
        if (mode == 9) a.v1x = '0;
        t = $urandom_range(0, 1 << 20);
        r = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 7) == 0) t = 0;
        cx = a.p1x + t * a.v1x;
        cy = a.p1y + t * a.v1y;
        a.p2x = cx - r * a.v2x;
        a.p2y = cy - r * a.v2y;
      end
    endcase
    return a;
  endfunction

  function automatic ray_pair_t mk(logic signed [PW-1:0] p1x, p1y,
                                   logic signed [VW-1:0] v1x, v1y,
                                   logic signed [PW-1:0] p2x, p2y,
                                   logic signed [VW-1:0] v2x, v2y);
    ray_pair_t a;
    a = '{1'b0, p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y};
    return a;
  endfunction

  initial begin
    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    ray_pair_t a;
    stimulus_done = 1'b0;
    pending_pairs.push_back(mk(PMAX, PMAX, VMAX, VMAX, PMAX, PMAX, VMAX, VMAX));
    pending_pairs.push_back(mk(PMIN, PMIN, VMIN, VMIN, PMIN, PMIN, VMIN, VMIN));
    pending_pairs.push_back(mk(PMAX, PMIN, VMAX, VMIN, PMIN, PMAX, VMIN, VMAX));
    pending_pairs.push_back(mk(PMIN, PMAX, VMIN, VMAX, PMAX, PMIN, VMAX, VMIN));
    pending_pairs.push_back(mk(0, 0, 1, 0, 10, 0, 1, 0));
    pending_pairs.push_back(mk(0, 0, 1, 1, 5, 0, 2, 2));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk(10, 10, 1, 1, 10, -10, 1, -1));
    pending_pairs.push_back(mk(0, 0, 1, 0, 5, -5, 0, -1));
    pending_pairs.push_back(mk(0, 0, -1, 0, 5, -5, 0, 1));
    pending_pairs.push_back(mk(0, 0, 1, 1, 10, 0, -1, 1));
    pending_pairs.push_back(mk(7, -3, 3, 5, 7, -3, -2, 4));
    pending_pairs.push_back(mk(0, -8, 0, 1, -4, 0, 1, 0));
    pending_pairs.push_back(mk(3, 8, 0, -2, -4, 1, 3, 0));
    pending_pairs.push_back(mk(PMAX, PMIN, 1, 1, PMAX, 0, 1, 0));
    pending_pairs.push_back(mk(PMIN, PMAX, -1, -1, PMIN, 0, -1, 0));
    pending_pairs.push_back(mk(0, 0, 3, 1, 1, 1, -3, 2));
    pending_pairs.push_back(mk(-1, -1, -7, 11, 2, 5, 13, -9));
    pending_pairs.push_back(mk(1, 0, VMAX, 1, 0, 1, 1, VMIN));
    a = mk(0, 0, 2, 1, 1, 5, 1, -2);
    a.hold = 1'b1;
    pending_pairs.push_back(a);
    for (int i = 0; i < N_RANDOM; i++) begin
      a = random_pair();
      a.hold = (i == N_RANDOM / 2);
      pending_pairs.push_back(a);
    end
    stimulus_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_ch.valid <= 1'b0;
      ray_ch.first_pos_x <= '0; ray_ch.first_pos_y <= '0;
      ray_ch.first_vel_x <= '0; ray_ch.first_vel_y <= '0;
      ray_ch.second_pos_x <= '0; ray_ch.second_pos_y <= '0;
      ray_ch.second_vel_x <= '0; ray_ch.second_vel_y <= '0;
      gap_left = 0;
      burst_left = 0;
      sent_cnt = 0;
    end else begin
      if (ray_ch.valid && ray_ch.ready) begin
        expected_crossings.push_back(crossing_of(cur_pair));
        sent_cnt++;
      end
      if (!(ray_ch.valid && !ray_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          ray_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].hold &&
                       (expected_crossings.size() != 0 || ray_ch.valid))) begin
          cur_pair = pending_pairs.pop_front();
          ray_ch.valid <= 1'b1;
          ray_ch.first_pos_x <= cur_pair.p1x; ray_ch.first_pos_y <= cur_pair.p1y;
          ray_ch.first_vel_x <= cur_pair.v1x; ray_ch.first_vel_y <= cur_pair.v1y;
          ray_ch.second_pos_x <= cur_pair.p2x; ray_ch.second_pos_y <= cur_pair.p2y;
          ray_ch.second_vel_x <= cur_pair.v2x; ray_ch.second_vel_y <= cur_pair.v2y;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          ray_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      got_cnt = 0;
    end else begin
      case (cyc[11:9])
        3'd2:    res_ch.ready <= 1'b1;
        3'd5:    res_ch.ready <= ($urandom_range(0, 3) == 0);
        3'd6:    res_ch.ready <= cyc[4];
        default: res_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
      if (res_ch.valid && res_ch.ready) begin
        got_cnt++;
        if (expected_crossings.size() == 0) begin
          $error("result transaction with nothing expected");
          fails++;
        end else begin
          want = expected_crossings.pop_front();
          status_cnt[want.status]++;
          if (res_ch.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, res_ch.status);
            fails++;
          end
          if (res_ch.point_x !== want.px) begin
            $error("point_x expected %0d got %0d", want.px, res_ch.point_x);
            fails++;
          end
          if (res_ch.point_y !== want.py) begin
            $error("point_y expected %0d got %0d", want.py, res_ch.point_y);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fails = 0;
    cyc = 0;
    status_cnt = '{0, 0, 0, 0};
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done);
    while (pending_pairs.size() != 0 || ray_ch.valid || expected_crossings.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d ray pairs sent, %0d results checked", sent_cnt, got_cnt);
    $display("crossings %0d, parallel %0d, behind second %0d, behind first %0d",
             status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3]);
    if (fails == 0 && expected_crossings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rc2d_pkg.sv
sv/rc2d_ifs.sv
sv/rc2d_front.sv
sv/rc2d_cell.sv
sv/ray_crossing_2d.sv
dv/ray_crossing_2d_test.sv
